// File: src/ima_adpcm_nibble_decoder_assert.svh
// assertion macros used by the checker of this block
`ifndef IMA_ADPCM_NIBBLE_DECODER_ASSERT_SVH
`define IMA_ADPCM_NIBBLE_DECODER_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define IMADEC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imadec assertion failed");

// next-cycle implication, disabled while reset is held
`define IMADEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imadec assertion failed");

`endif

// File: src/imadec_pkg.sv
`default_nettype none

package imadec_pkg;

    localparam int unsigned IDX_W    = 7;
    localparam int unsigned STEP_W   = 15;
    localparam int unsigned DIF_W    = 17;
    localparam int unsigned SUM_W    = 18;

    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(88);

    localparam logic signed [SUM_W-1:0] SAMPLE_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAMPLE_MIN = -SUM_W'(32768);

    // action codes
    localparam logic ACT_HEADER = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    typedef struct packed {
        logic               action;
        logic signed [15:0] header_sample;
        logic [7:0]         header_index;
        logic [7:0]         code_byte;
        logic               nibble_high;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] pcm_sample;
        logic [7:0]         pwm_level;
    } t_out_word;

    typedef struct packed {
        logic signed [15:0] predictor;
        logic [IDX_W-1:0]   step_index;
    } t_state;

    // standard 89-entry step size table, out-of-range index reads the last entry
    function automatic logic [STEP_W-1:0] step_size(input logic [IDX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

    // sample / 256 toward zero, plus 128
    function automatic logic [7:0] pwm_of(input logic signed [15:0] smp);
        logic signed [7:0] q;
        q = smp[15:8];
        if (smp[15] && (smp[7:0] != 8'd0)) begin
            q = q + 8'sd1;
        end
        return {~q[7], q[6:0]};
    endfunction

endpackage

`default_nettype wire

// File: src/imadec_step.sv
`default_nettype none

module imadec_step import imadec_pkg::*; (
    input  t_state     i_state,
    input  logic [3:0] i_code,
    output t_state     o_state,
    output logic [7:0] o_level
);

    logic [IDX_W-1:0]         idx_c;
    logic [STEP_W-1:0]        stp;
    logic [DIF_W-1:0]         dif;
    logic signed [SUM_W-1:0]  pred_x;
    logic signed [SUM_W-1:0]  sum;
    logic signed [15:0]       sat;
    logic [IDX_W-1:0]         idx_up;

    always_comb begin
        idx_c = (i_state.step_index > IDX_MAX) ? IDX_MAX : i_state.step_index;
        stp   = step_size(idx_c);

        dif = DIF_W'(stp >> 3);
        if (i_code[2]) dif = dif + DIF_W'(stp);
        if (i_code[1]) dif = dif + DIF_W'(stp >> 1);
        if (i_code[0]) dif = dif + DIF_W'(stp >> 2);

        pred_x = SUM_W'(i_state.predictor);
        if (i_code[3]) begin
            sum = pred_x - $signed({1'b0, dif});
        end else begin
            sum = pred_x + $signed({1'b0, dif});
        end

        if (sum > SAMPLE_MAX)      sat = 16'sh7fff;
        else if (sum < SAMPLE_MIN) sat = 16'sh8000;
        else                       sat = sum[15:0];

        // magnitude 4..7 moves up by 2, 4, 6 or 8
        idx_up = idx_c + IDX_W'({i_code[1:0], 1'b0}) + IDX_W'(2);
        if (!i_code[2]) begin
            o_state.step_index = (idx_c != '0) ? idx_c - IDX_W'(1) : '0;
        end else begin
            o_state.step_index = (idx_up > IDX_MAX) ? IDX_MAX : idx_up;
        end

        o_state.predictor = sat;
        o_level           = pwm_of(sat);
    end

endmodule

`default_nettype wire

// File: src/ima_adpcm_nibble_decoder.sv
// ima adpcm nibble decoder: one 4-bit code per word, one pcm word out per decode
// a word passes through the input register, then the result register
// throughput: one word per cycle while the result side does not stall, set by the combinational predictor/index update
// header words update predictor and step index and produce no result
// reset (i_rst_n low, synchronous) empties both registers, clears predictor and index
`default_nettype none

module ima_adpcm_nibble_decoder import imadec_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input word channel
    input  logic      i_in_valid,
    input  t_in_word  i_in_data,
    output logic      o_in_stall,
    // result word channel
    output logic      o_out_valid,
    output t_out_word o_out_data,
    input  logic      i_out_stall
);

    // input register
    logic      r_a_valid;
    t_in_word  r_a;

    // decoder state carried from word to word
    t_state    r_state;
    t_state    n_state;

    // result register
    logic      r_out_valid;
    t_out_word r_out;

    logic       out_free;
    logic       a_adv;
    logic       in_acc;
    logic [3:0] code;
    t_state     dec_state;
    logic [7:0] dec_level;

    // result register can take a new word when empty or being drained
    assign out_free = !r_out_valid || !i_out_stall;

    // header words never need the result register, so they always move on
    assign a_adv  = r_a_valid && ((r_a.action == ACT_HEADER) || out_free);
    assign in_acc = i_in_valid && !o_in_stall;

    // stall only when the held word cannot move this cycle
    assign o_in_stall = r_a_valid && !a_adv;

    // pick the nibble
    assign code = r_a.nibble_high ? r_a.code_byte[7:4] : r_a.code_byte[3:0];

    imadec_step u_step (
        .i_state (r_state),
        .i_code  (code),
        .o_state (dec_state),
        .o_level (dec_level)
    );

    // next state: header load with index saturated at 88, decoded update for a decode word, else held
    always_comb begin
        n_state = r_state;
        if (a_adv) begin
            if (r_a.action == ACT_HEADER) begin
                n_state.predictor  = r_a.header_sample;
                n_state.step_index = (r_a.header_index > 8'(IDX_MAX)) ?
                                     IDX_MAX : r_a.header_index[IDX_W-1:0];
            end else begin
                n_state = dec_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            r_state   <= n_state;
            r_a_valid <= in_acc || (r_a_valid && !a_adv);

            if (a_adv && (r_a.action == ACT_DECODE)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a <= i_in_data;
        end
        if (a_adv && (r_a.action == ACT_DECODE)) begin
            r_out.pcm_sample <= dec_state.predictor;
            r_out.pwm_level  <= dec_level;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: src/imadec_checker.sv
`default_nettype none

`include "ima_adpcm_nibble_decoder_assert.svh"

module imadec_checker import imadec_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire t_in_word  i_in_data,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire t_out_word o_out_data,
    input wire logic      i_out_stall
);

    logic in_acc;
    logic [7:0] exp_level;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign exp_level = pwm_of(o_out_data.pcm_sample);

    // a held result keeps its payload
    `IMADEC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_data))

    // input is only pushed back while the result side is stalled
    `IMADEC_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_in_stall, i_out_stall && o_out_valid)

    // level matches the sample whenever a result is valid
    `IMADEC_ASSERT_SAME(a_level, i_clk, i_rst_n, o_out_valid, o_out_data.pwm_level == exp_level)

    // a fresh result comes from a decode word that was taken and passed through the input register
    `IMADEC_ASSERT_SAME(a_rise_src, i_clk, i_rst_n, $rose(o_out_valid),
        $past(in_acc, 2) && ($past(i_in_data.action, 2) == ACT_DECODE))

endmodule

bind ima_adpcm_nibble_decoder imadec_checker u_imadec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

`default_nettype wire
